// ----- design/nsfbm_pkg.sv -----
`default_nettype none
package nsfbm_pkg;

  localparam int MAX_BANKS  = 256;
  localparam int STUB_BYTES = 54;

  localparam logic [7:0] BANK_LIMIT_MASK = 8'(MAX_BANKS - 1);

  localparam logic [15:0] ADDR_STUB      = 16'h3800;
  localparam logic [15:0] ADDR_STUB_END  = 16'(32'h3800 + STUB_BYTES);
  localparam logic [15:0] ADDR_REG_LO    = 16'h4020;
  localparam logic [15:0] ADDR_REG_HI    = 16'h5FFF;
  localparam logic [15:0] ADDR_RELOAD    = 16'h5FF0;
  localparam logic [15:0] ADDR_SONG      = 16'h5FF1;
  localparam logic [15:0] ADDR_PLAY      = 16'h5FF2;
  localparam logic [15:0] ADDR_PAL       = 16'h5FF3;
  localparam logic [12:0] ADDR_BANK_PAGE = 13'h0BFF;

  localparam logic [3:0] PC_PAGE_DRIVER = 4'd3;

  localparam logic [5:0] STUB_INIT_LO = 6'h28;
  localparam logic [5:0] STUB_INIT_HI = 6'h29;
  localparam logic [5:0] STUB_PLAY_LO = 6'h2B;
  localparam logic [5:0] STUB_PLAY_HI = 6'h2C;

  localparam logic [7:0] SONG_RESET   = 8'd1;
  localparam logic [7:0] RELOAD_START = 8'h01;
  localparam logic [7:0] RELOAD_PANEL = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PANEL = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CTRL_NONE = 2'd0,
    CTRL_NEXT = 2'd1,
    CTRL_PREV = 2'd2,
    CTRL_RSVD = 2'd3
  } ctrl_t;

  typedef enum logic [1:0] {
    SRC_OPEN     = 2'd0,
    SRC_DATA     = 2'd1,
    SRC_ROM      = 2'd2,
    SRC_UNMAPPED = 2'd3
  } src_t;

  typedef enum logic [3:0] {
    CFG_BANK_INIT     = 4'd0,
    CFG_BANK_MASK     = 4'd1,
    CFG_LOAD_PAGE     = 4'd2,
    CFG_PAL_FLAG      = 4'd3,
    CFG_STARTING_SONG = 4'd4,
    CFG_TOTAL_SONGS   = 4'd5,
    CFG_INIT_ADDR     = 4'd6,
    CFG_PLAY_ADDR     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] bank_init;
    logic [7:0]  bank_mask;
    logic [2:0]  load_page;
    logic        pal_flag;
    logic [7:0]  starting_song;
    logic [7:0]  total_songs;
    logic [15:0] init_addr;
    logic [15:0] play_addr;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [3:0]  pc_page;
    logic [1:0]  control;
  } item_t;

  typedef struct packed {
    src_t        data_source;
    logic [7:0]  read_data;
    logic [19:0] rom_address;
    logic        sound_reset;
  } result_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

  localparam logic [7:0] STUB_BASE [64] = '{
    8'h08, 8'h48, 8'h8A, 8'h48, 8'h98, 8'h48, 8'hA9, 8'hFF,
    8'h8D, 8'hF2, 8'h5F, 8'h68, 8'hA8, 8'h68, 8'hAA, 8'h68,
    8'h28, 8'h40, 8'hAD, 8'hF2, 8'h5F, 8'hF0, 8'hFB, 8'hA9,
    8'h00, 8'h8D, 8'hF2, 8'h5F, 8'hAD, 8'hF0, 8'h5F, 8'hF0,
    8'h09, 8'hAD, 8'hF1, 8'h5F, 8'hAE, 8'hF3, 8'h5F, 8'h20,
    8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h4C, 8'h12, 8'h38,
    8'hA2, 8'hFF, 8'h9A, 8'h4C, 8'h12, 8'h38, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] mask_bank(input logic [7:0] bank, input logic [7:0] msk);
    return bank & msk & BANK_LIMIT_MASK;
  endfunction

  function automatic logic [7:0] stub_byte(input logic [5:0] off,
                                           input logic [15:0] init_a,
                                           input logic [15:0] play_a);
    logic [7:0] b;
    case (off)
      STUB_INIT_LO: b = init_a[7:0];
      STUB_INIT_HI: b = init_a[15:8];
      STUB_PLAY_LO: b = play_a[7:0];
      STUB_PLAY_HI: b = play_a[15:8];
      default:      b = STUB_BASE[off];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- design/nsfbm_cfg_regs.sv -----
`default_nettype none
module nsfbm_cfg_regs
  import nsfbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BANK_INIT:     cfg_nxt.bank_init     = cfg_data;
        CFG_BANK_MASK:     cfg_nxt.bank_mask     = cfg_data[7:0];
        CFG_LOAD_PAGE:     cfg_nxt.load_page     = cfg_data[2:0];
        CFG_PAL_FLAG:      cfg_nxt.pal_flag      = cfg_data[0];
        CFG_STARTING_SONG: cfg_nxt.starting_song = cfg_data[7:0];
        CFG_TOTAL_SONGS:   cfg_nxt.total_songs   = cfg_data[7:0];
        CFG_INIT_ADDR:     cfg_nxt.init_addr     = cfg_data[15:0];
        CFG_PLAY_ADDR:     cfg_nxt.play_addr     = cfg_data[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bank_init     <= 64'd0;
      cfg_r.bank_mask     <= 8'hFF;
      cfg_r.load_page     <= 3'd0;
      cfg_r.pal_flag      <= 1'b0;
      cfg_r.starting_song <= 8'd1;
      cfg_r.total_songs   <= 8'd1;
      cfg_r.init_addr     <= 16'h8000;
      cfg_r.play_addr     <= 16'h8003;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- design/nsfbm_in_reg.sv -----
`default_nettype none
module nsfbm_in_reg
  import nsfbm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire item_t in_item,
  input  wire logic take,
  output stage_ctl_t ctl,
  output item_t     item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.take  = take;
  assign item      = item_r;

endmodule
`default_nettype wire

// ----- design/nsfbm_exec.sv -----
`default_nettype none
module nsfbm_exec
  import nsfbm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire stage_ctl_t ctl,
  input  wire item_t item,
  input  wire logic out_stall,
  output logic      take,
  output logic      out_valid,
  output result_t   res
);

  logic [7:0] slot_bank_r [8];
  logic [7:0] slot_bank_nxt [8];
  logic [7:0] slot_valid_r;
  logic [7:0] slot_valid_nxt;
  logic [7:0] reload_flag_r;
  logic [7:0] reload_flag_nxt;
  logic [7:0] song_number_r;
  logic [7:0] song_number_nxt;
  logic [7:0] play_pending_r;
  logic [7:0] play_pending_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  result_t    res_r;
  result_t    res_nxt;

  logic       go;
  logic       switching;
  logic       page3;
  logic [2:0] slot;

  assign take      = !out_valid_r || !out_stall;
  assign go        = ctl.valid && ctl.take;
  assign switching = |cfg.bank_init;
  assign page3     = item.pc_page == PC_PAGE_DRIVER;
  assign slot      = item.address[14:12];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      slot_bank_nxt[i] = slot_bank_r[i];
    end
    slot_valid_nxt   = slot_valid_r;
    reload_flag_nxt  = reload_flag_r;
    song_number_nxt  = song_number_r;
    play_pending_nxt = play_pending_r;
    res_nxt.data_source = SRC_OPEN;
    res_nxt.read_data   = 8'd0;
    res_nxt.rom_address = 20'd0;
    res_nxt.sound_reset = 1'b0;

    case (item.op)
      OP_START: begin
        for (int i = 0; i < 8; i++) begin
          if (switching) begin
            slot_bank_nxt[i]  = mask_bank(cfg.bank_init[8*i +: 8], cfg.bank_mask);
            slot_valid_nxt[i] = 1'b1;
          end else if (3'(i) >= cfg.load_page) begin
            slot_bank_nxt[i]  = mask_bank({5'd0, 3'(i) - cfg.load_page}, cfg.bank_mask);
            slot_valid_nxt[i] = 1'b1;
          end else begin
            slot_bank_nxt[i]  = 8'd0;
            slot_valid_nxt[i] = 1'b0;
          end
        end
        song_number_nxt = cfg.starting_song;
        reload_flag_nxt = RELOAD_START;
      end
      OP_PANEL: begin
        if (item.control == CTRL_NEXT) begin
          if (song_number_r < cfg.total_songs) begin
            song_number_nxt = song_number_r + 8'd1;
          end
        end else if (item.control == CTRL_PREV) begin
          if (song_number_r > 8'd1) begin
            song_number_nxt = song_number_r - 8'd1;
          end
        end
        reload_flag_nxt = RELOAD_PANEL;
      end
      OP_WRITE: begin
        if (item.address == ADDR_PLAY) begin
          if (page3) begin
            play_pending_nxt = item.write_data;
          end
        end else if (item.address[15:3] == ADDR_BANK_PAGE) begin
          if (switching) begin
            slot_bank_nxt[item.address[2:0]]  = mask_bank(item.write_data, cfg.bank_mask);
            slot_valid_nxt[item.address[2:0]] = 1'b1;
          end
        end
      end
      default: begin
        if (item.address >= ADDR_STUB && item.address < ADDR_STUB_END) begin
          res_nxt.data_source = SRC_DATA;
          res_nxt.read_data   = stub_byte(item.address[5:0], cfg.init_addr, cfg.play_addr);
        end else if (item.address >= ADDR_REG_LO && item.address <= ADDR_REG_HI) begin
          res_nxt.data_source = SRC_DATA;
          if (page3) begin
            case (item.address)
              ADDR_RELOAD: begin
                res_nxt.read_data = reload_flag_r;
                reload_flag_nxt   = 8'd0;
              end
              ADDR_SONG: begin
                res_nxt.sound_reset = 1'b1;
                res_nxt.read_data   = song_number_r - 8'd1;
                if (switching) begin
                  for (int i = 0; i < 8; i++) begin
                    slot_bank_nxt[i]  = mask_bank(cfg.bank_init[8*i +: 8], cfg.bank_mask);
                    slot_valid_nxt[i] = 1'b1;
                  end
                end
              end
              ADDR_PLAY: res_nxt.read_data = play_pending_r;
              ADDR_PAL:  res_nxt.read_data = {7'd0, cfg.pal_flag};
              default:   res_nxt.read_data = 8'd0;
            endcase
          end
        end else if (item.address[15]) begin
          if (slot_valid_r[slot]) begin
            res_nxt.data_source = SRC_ROM;
            res_nxt.rom_address = {slot_bank_r[slot], item.address[11:0]};
          end else begin
            res_nxt.data_source = SRC_UNMAPPED;
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        slot_bank_r[i] <= 8'd0;
      end
      slot_valid_r   <= 8'd0;
      reload_flag_r  <= RELOAD_START;
      song_number_r  <= SONG_RESET;
      play_pending_r <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (go) begin
        for (int i = 0; i < 8; i++) begin
          slot_bank_r[i] <= slot_bank_nxt[i];
        end
        slot_valid_r   <= slot_valid_nxt;
        reload_flag_r  <= reload_flag_nxt;
        song_number_r  <= song_number_nxt;
        play_pending_r <= play_pending_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

`ifndef SYNTHESIS
  a_reset_pulse_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sound_reset |-> res_r.data_source == SRC_DATA)
    else $error("sound reset outside a register read");

  a_rom_addr_only_rom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.data_source != SRC_ROM |-> res_r.rom_address == 20'd0)
    else $error("rom address set on a non-rom result");

  a_start_switched_valid: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.op == OP_START && switching |=> slot_valid_r == 8'hFF)
    else $error("slots not all valid after switched start");

  a_panel_sets_reload: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.op == OP_PANEL |=> reload_flag_r == RELOAD_PANEL)
    else $error("reload flag not set by panel event");

  a_no_take_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> out_valid_r && $stable(res_r))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

// ----- design/nsf_player_bank_mapper_unit.sv -----
// Bank mapper for a music-file player.
// Input channel (in_valid/in_stall) carries one bus or panel item: CPU read,
// CPU write, panel next/previous event or start. Each item yields exactly one
// result on the output channel (out_valid/out_stall): data source code, read
// byte, 20-bit ROM address and a one-item sound reset pulse.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user writes them only while no item is in flight, and the block has
// no check for it. Indexes above 7 are ignored. An accepted item passes
// through the input register and then the result register. Throughput: one
// item per cycle while out_stall is low, set by the single execution stage
// that reads and updates the bank slots and song registers between the two.
// Reset (rst_n low, synchronous): empties both registers, loads the
// configuration defaults, clears the bank slots, sets the reload byte to 1
// and the song to 1.
// While out_stall is high the result holds; one more item fills the input
// register and then in_stall rises until the result is taken.
`default_nettype none
module nsf_player_bank_mapper_unit
  import nsfbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [3:0]  in_pc_page,
  input  wire logic [1:0]  in_control,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_data_source,
  output logic [7:0]       out_read_data,
  output logic [19:0]      out_rom_address,
  output logic             out_sound_reset,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t       cfg;
  item_t      in_item;
  item_t      item;
  stage_ctl_t ctl;
  result_t    res;
  logic       take;

  assign in_item.op         = op_t'(in_op);
  assign in_item.address    = in_address;
  assign in_item.write_data = in_write_data;
  assign in_item.pc_page    = in_pc_page;
  assign in_item.control    = in_control;

  nsfbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nsfbm_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .ctl      (ctl),
    .item     (item)
  );

  nsfbm_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctl       (ctl),
    .item      (item),
    .out_stall (out_stall),
    .take      (take),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_data_source = res.data_source;
  assign out_read_data   = res.read_data;
  assign out_rom_address = res.rom_address;
  assign out_sound_reset = res.sound_reset;

endmodule
`default_nettype wire
